/* rtl/mavdz_pkg.sv */
// mavdz_pkg: shared constants and types of the moving-average dead-zone filter
// used by every module under rtl/, no dependencies

package mavdz_pkg;

  localparam int SAMPLE_W   = 12;
  localparam int WINDOW_DEF = 16;

  localparam logic [SAMPLE_W-1:0] MID_SCALE  = 12'd2048;
  localparam logic [SAMPLE_W-1:0] DZ_DEFAULT = 12'd10;

  // control from the sequencer to the sample ring
  typedef struct packed {
    logic load;    // word accepted: capture sample, read oldest entry
    logic update;  // write ring, update running sum and position
  } mavdz_ring_ctl_t;

endpackage

/* rtl/mavdz_ring.sv */
// mavdz_ring: sample ring memory, running sum, write position and full flag
// depends on mavdz_pkg

module mavdz_ring
  import mavdz_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEF,
  parameter int SUM_W  = $clog2(WINDOW * 4095 + 1),
  parameter int CNT_W  = $clog2(WINDOW + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mavdz_ring_ctl_t     ctl,
  input  logic [SAMPLE_W-1:0] sample,
  output logic [SUM_W-1:0]    sum,
  output logic [CNT_W-1:0]    count
);

  localparam int POS_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  logic [SAMPLE_W-1:0] ring_mem [WINDOW];
  logic [SAMPLE_W-1:0] rd_data_r;
  logic [SAMPLE_W-1:0] sample_r;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic                full_r, full_nxt;

  // memory: read the entry about to be overwritten when the word arrives
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      rd_data_r <= ring_mem[pos_r];
      sample_r  <= sample;
    end
    if (ctl.update) begin
      ring_mem[pos_r] <= sample_r;
    end
  end

  always_comb begin
    pos_nxt  = pos_r;
    sum_nxt  = sum_r;
    full_nxt = full_r;
    if (ctl.update) begin
      // oldest sample leaves the sum only once the ring has wrapped
      sum_nxt = sum_r + SUM_W'(sample_r) - (full_r ? SUM_W'(rd_data_r) : '0);
      if (pos_r == POS_W'(WINDOW - 1)) begin
        pos_nxt  = '0;
        full_nxt = 1'b1;
      end else begin
        pos_nxt = pos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      sum_r  <= '0;
      full_r <= 1'b0;
    end else begin
      pos_r  <= pos_nxt;
      sum_r  <= sum_nxt;
      full_r <= full_nxt;
    end
  end

  assign sum   = sum_r;
  assign count = full_r ? CNT_W'(WINDOW) : CNT_W'(pos_r);

endmodule

/* rtl/mavdz_div.sv */
// mavdz_div: bit-serial restoring divider, one quotient bit per cycle
// depends on mavdz_pkg; quotient is known to fit in SAMPLE_W bits

module mavdz_div
  import mavdz_pkg::*;
#(
  parameter int SUM_W = 18,
  parameter int CNT_W = 5
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [SUM_W-1:0]    dividend,
  input  logic [CNT_W-1:0]    divisor,
  output logic                done,
  output logic [SAMPLE_W-1:0] quotient
);

  localparam int STEP_W = $clog2(SAMPLE_W);

  logic [CNT_W-1:0]    rem_r, rem_nxt;
  logic [SAMPLE_W-1:0] shf_r, shf_nxt;  // dividend bits out at top, quotient bits in at bottom
  logic [CNT_W-1:0]    dsr_r;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [CNT_W:0]      trial;
  logic                ge;

  assign trial = {rem_r, shf_r[SAMPLE_W-1]};
  assign ge    = (trial >= {1'b0, dsr_r});

  always_comb begin
    rem_nxt  = rem_r;
    shf_nxt  = shf_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      // upper dividend bits are already below the divisor
      rem_nxt  = CNT_W'(dividend >> SAMPLE_W);
      shf_nxt  = dividend[SAMPLE_W-1:0];
      step_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt  = ge ? CNT_W'(trial - {1'b0, dsr_r}) : trial[CNT_W-1:0];
      shf_nxt  = {shf_r[SAMPLE_W-2:0], ge};
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(SAMPLE_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    shf_r  <= shf_nxt;
    step_r <= step_nxt;
    if (start) begin
      dsr_r <= divisor;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = shf_r;

endmodule

/* rtl/moving_average_deadzone_filter_top.sv */
// Moving-average filter with dead band for one 12-bit ADC axis. Each input word
// is one sample; each produces one result word carrying the truncated average of
// the last WINDOW samples (of all samples seen, until the ring first fills) and
// the dead-zone qualified stable value, which follows the average only when it
// moves by at least cfg dead zone (reset 10) and starts at mid-scale 2048.
// Samples are taken one at a time; the next is accepted only after the last has
// passed through acceptance, the update of the ring and running sum, the loading
// of the divider, the bit-serial divider (12 quotient bits, one per cycle) and
// the dead zone step into the output register, which may stall on out_ready. A
// finished result waits in the output register while the next sample is
// accepted. The ring memory needs no clearing after reset.
// depends on mavdz_pkg, mavdz_ring, mavdz_div

module moving_average_deadzone_filter_top
  import mavdz_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [SAMPLE_W-1:0] in_sample,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [SAMPLE_W-1:0] out_stable_value,
  output logic [SAMPLE_W-1:0] out_average,
  input  logic                cfg_wr_en,
  input  logic [SAMPLE_W-1:0] cfg_wr_data
);

  localparam int SUM_W = $clog2(WINDOW * 4095 + 1);
  localparam int CNT_W = $clog2(WINDOW + 1);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SUM  = 5'b00010,
    ST_LOAD = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

  state_t              state_r, state_nxt;
  mavdz_ring_ctl_t     ring_ctl;
  logic [SUM_W-1:0]    ring_sum;
  logic [CNT_W-1:0]    ring_count;
  logic                div_start;
  logic                div_done;
  logic [SAMPLE_W-1:0] div_quot;
  logic [SAMPLE_W-1:0] avg_r;
  logic [SAMPLE_W-1:0] held_r, held_nxt;
  logic [SAMPLE_W-1:0] dz_r;
  logic [SAMPLE_W-1:0] diff;
  logic [SAMPLE_W-1:0] out_stable_r, out_avg_r;
  logic                out_valid_r, out_valid_nxt;
  logic                in_fire;
  logic                out_load;

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_load = (state_r == ST_OUT) && (!out_valid_r || out_ready);

  assign ring_ctl.load   = in_fire;
  assign ring_ctl.update = (state_r == ST_SUM);
  assign div_start       = (state_r == ST_LOAD);

  mavdz_ring #(
    .WINDOW (WINDOW),
    .SUM_W  (SUM_W),
    .CNT_W  (CNT_W)
  ) u_ring (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ring_ctl),
    .sample (in_sample),
    .sum    (ring_sum),
    .count  (ring_count)
  );

  mavdz_div #(
    .SUM_W (SUM_W),
    .CNT_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (ring_sum),
    .divisor  (ring_count),
    .done     (div_done),
    .quotient (div_quot)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_fire) state_nxt = ST_SUM;
      ST_SUM:  state_nxt = ST_LOAD;
      ST_LOAD: state_nxt = ST_DIV;
      ST_DIV:  if (div_done) state_nxt = ST_OUT;
      ST_OUT:  if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // dead band: keep the held value on small moves of the average
  assign diff     = (avg_r >= held_r) ? (avg_r - held_r) : (held_r - avg_r);
  assign held_nxt = (out_load && !(diff < dz_r)) ? avg_r : held_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DIV && div_done) begin
      avg_r <= div_quot;
    end
    if (out_load) begin
      out_stable_r <= held_nxt;
      out_avg_r    <= avg_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      held_r      <= MID_SCALE;
      dz_r        <= DZ_DEFAULT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        dz_r <= cfg_wr_data;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_stable_value = out_stable_r;
  assign out_average      = out_avg_r;

`ifndef ASSERT_OFF
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV))
    else $error("divider finished outside the divide phase");

  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOAD) |-> (ring_count != '0))
    else $error("divider started with a zero sample count");

  a_held_only_on_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_OUT) |=> $stable(held_r))
    else $error("held value changed outside the output phase");
`endif

endmodule

/* test/tb_moving_average_deadzone_filter_top.sv */
`timescale 1ns / 100ps
// Self-checking bench for moving_average_deadzone_filter_top: queue-fed driver,
// clocked monitor, and a behavioral predictor of the window average and dead zone.
// Depends on mavdz_pkg and the filter RTL.

module tb_moving_average_deadzone_filter_top;
  import mavdz_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 40;
  localparam int SUM_W = $clog2(WINDOW_DEF * 4096);
  localparam logic [SAMPLE_W-1:0] FULL_SCALE = '1;

  typedef logic [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    sample_t stable_value;
    sample_t average;
  } filter_word_t;

  logic    clk = 1'b0;
  logic    rst_n = 1'b0;
  logic    in_valid = 1'b0;
  logic    in_ready;
  sample_t in_sample = '0;
  logic    out_valid;
  logic    out_ready = 1'b0;
  sample_t out_stable_value;
  sample_t out_average;
  logic    cfg_wr_en = 1'b0;
  sample_t cfg_wr_data = '0;

  // predictor state
  sample_t          window_hist [WINDOW_DEF];
  int               hist_pos = 0;
  logic [SUM_W-1:0] window_sum = '0;
  logic             window_filled = 1'b0;
  sample_t          held_level = MID_SCALE;
  sample_t          dead_band = DZ_DEFAULT;

  sample_t      sample_pending [$];
  filter_word_t predicted_q [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatches = 0;
  int samples_sent = 0;
  int words_checked = 0;
  int stall_cycles = 0;
  int drift_level = 2048;

  moving_average_deadzone_filter_top #(.WINDOW(WINDOW_DEF)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_sample        (in_sample),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_stable_value (out_stable_value),
    .out_average      (out_average),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic filter_word_t filter_step(input sample_t s);
    filter_word_t res;
    int divisor;
    sample_t avg;
    sample_t gap;
    // oldest entry leaves the sum only once the window has wrapped
    if (window_filled) window_sum = window_sum - window_hist[hist_pos];
    window_sum = window_sum + s;
    window_hist[hist_pos] = s;
    hist_pos = (hist_pos + 1) % WINDOW_DEF;
    if (hist_pos == 0) window_filled = 1'b1;
    divisor = window_filled ? WINDOW_DEF : hist_pos;
    avg = sample_t'(window_sum / divisor);
    gap = (avg >= held_level) ? avg - held_level : held_level - avg;
    if (!(gap < dead_band)) held_level = avg;
    res.stable_value = held_level;
    res.average = avg;
    return res;
  endfunction

  // driver: one word in flight on the input, held until taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predicted_q.push_back(filter_step(in_sample));
        samples_sent <= samples_sent + 1;
      end
      if (!in_valid || in_ready) begin
        if (sample_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_sample <= sample_pending.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    filter_word_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        words_checked <= words_checked + 1;
        if (predicted_q.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("unexpected word: stable %0d average %0d", out_stable_value,
                     out_average);
        end else begin
          want = predicted_q.pop_front();
          if (out_stable_value !== want.stable_value || out_average !== want.average)
          begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("mismatch: stable exp %0d got %0d, average exp %0d got %0d",
                       want.stable_value, out_stable_value, want.average, out_average);
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("no progress for %0d cycles", STALL_LIMIT);
      $display("tb_moving_average_deadzone_filter_top NOT OK");
      $finish;
    end
  end

  task automatic write_dead_band(input sample_t value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    dead_band = value;
  endtask

  task automatic wait_drained();
    while (sample_pending.size() != 0 || in_valid || predicted_q.size() != 0)
      @(negedge clk);
  endtask

  // mostly a slowly drifting level with small noise, plus steps, uniform random values and rail hits
  task automatic queue_random(input int n);
    int k;
    int pick;
    int v;
    for (k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        v = drift_level + int'($urandom_range(24)) - 12;
      end else if (pick < 60) begin
        drift_level = $urandom_range(4095);
        v = drift_level;
      end else if (pick < 80) begin
        v = $urandom_range(4095);
      end else if (pick < 90) begin
        v = $urandom_range(1) ? 4095 : 0;
      end else begin
        drift_level = drift_level + int'($urandom_range(80)) - 40;
        v = drift_level;
      end
      if (drift_level < 0) drift_level = 0;
      if (drift_level > 4095) drift_level = 4095;
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      sample_pending.push_back(v[SAMPLE_W-1:0]);
    end
  endtask

  task automatic run_phase(input sample_t dz, input int n, input int s_idle,
                           input int r_idle);
    wait_drained();
    write_dead_band(dz);
    @(negedge clk);
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    queue_random(n);
  endtask

  initial begin
    sample_t directed [24] = '{
      FULL_SCALE, 12'd0, FULL_SCALE, 12'd0, MID_SCALE, 12'd2047, 12'd2049, 12'd1,
      12'd4094, 12'd2730, 12'd1365, FULL_SCALE, FULL_SCALE, FULL_SCALE, FULL_SCALE,
      FULL_SCALE, 12'd0, 12'd0, 12'd0, 12'd2058, 12'd2038, MID_SCALE, FULL_SCALE, 12'd0
    };
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    // partial-window averages, the wrap into a full window, both rails
    write_dead_band(DZ_DEFAULT);
    @(negedge clk);
    send_idle_pct = 12;
    recv_idle_pct = 60;
    foreach (directed[i]) sample_pending.push_back(directed[i]);

    // zero dead band: stable value always follows the average
    run_phase(12'd0, 150, 12, 60);
    run_phase(FULL_SCALE, 100, 12, 60);
    run_phase(12'd1, 150, 60, 12);
    run_phase(sample_t'($urandom_range(4095)), 150, 60, 12);
    run_phase(DZ_DEFAULT, 150, 0, 0);
    run_phase(sample_t'($urandom_range(64)), 125, 0, 0);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (predicted_q.size() != 0) begin
      mismatches = mismatches + predicted_q.size();
      $display("%0d expected words never arrived", predicted_q.size());
    end
    $display("%0d samples in, %0d words checked over 7 dead-band settings", samples_sent,
             words_checked);
    $display("dead band covered 0, 1, default, full scale and random; %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("tb_moving_average_deadzone_filter_top OK");
    end else begin
      $display("tb_moving_average_deadzone_filter_top NOT OK");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/mavdz_pkg.sv
rtl/mavdz_ring.sv
rtl/mavdz_div.sv
rtl/moving_average_deadzone_filter_top.sv
test/tb_moving_average_deadzone_filter_top.sv
